FILE: rtl/rmoe_pkg.sv
// Shared types and constants for the range map to address-map entry block.
// Used by every RTL file and by the checker; depends on nothing.
`default_nettype none

package rmoe_pkg;

    localparam logic [31:0] INVALID_TO = 32'h8000_0000;

    localparam logic OP_PAIR   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic CFG_WINDOW_START = 1'b0;
    localparam logic CFG_WINDOW_END   = 1'b1;

    localparam logic [31:0] WINDOW_END_RESET = 32'h8000_0000;

    typedef struct packed {
        logic        op;
        logic [30:0] img_base;
        logic [31:0] img_len;
        logic [30:0] src_base;
        logic [31:0] src_len;
    } in_item_t;

    typedef struct packed {
        logic [31:0] map_from;
        logic [31:0] map_to;
        logic        last_of_run;
        logic        truncated;
    } out_item_t;

    typedef struct packed {
        logic [33:0] next_addr;
        logic        reached;
    } step_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_GAP,
        S_BODY,
        S_CAP
    } rmoe_state_t;

endpackage

`default_nettype wire

FILE: rtl/rmoe_step_unit.sv
// Shared step unit: advances the repeat address by the old size and decides
// whether the repeat sequence ends. Depends on rmoe_pkg.
`default_nettype none

module rmoe_step_unit #(
    parameter int MAX_REPEATS = 32
) (
    input  wire logic [33:0]                        acc,
    input  wire logic [31:0]                        step,
    input  wire logic [32:0]                        limit,
    input  wire logic [$clog2(MAX_REPEATS+1)-1:0]   cnt,
    output rmoe_pkg::step_res_t                     res
);
    import rmoe_pkg::*;

    localparam int CNT_W = $clog2(MAX_REPEATS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_REPEATS - 1);

    logic [33:0] sum;

    assign sum = acc + {2'b00, step};

    always_comb
    begin
        res.next_addr = sum;
        res.reached   = (sum >= {1'b0, limit}) || (cnt == CNT_LAST);
    end

endmodule

`default_nettype wire

FILE: rtl/range_map_to_omap_entries.sv
// Flow: an accepted request passes through the setup states S_MUL and S_CHECK, then one entry per cycle
// while the output side takes them; a skipped request frees the input after S_CHECK.
// A new request is taken only in S_IDLE, once every entry of the previous request is pushed.
// Reset: asynchronous, active low; clears the run, the sequencer and the output
// valid, and returns the window registers to their reset values.
// Top level of the range map to address-map entry block; depends on rmoe_pkg, rmoe_step_unit.
`default_nettype none

module range_map_to_omap_entries #(
    parameter int MAX_REPEATS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire rmoe_pkg::in_item_t  in_item,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      rmoe_pkg::out_item_t out_item,
    input  wire logic                cfg_valid,
    output      logic                cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [31:0]         cfg_data
);
    import rmoe_pkg::*;

    localparam int CNT_W  = $clog2(MAX_REPEATS + 1);
    localparam int PROD_W = 32 + CNT_W;

    rmoe_state_t       state_reg, state_next;
    in_item_t          item_reg, item_next;
    logic [30:0]       ws_reg;
    logic [31:0]       we_reg;
    logic [32:0]       ra_reg, ra_next;
    logic              started_reg, started_next;
    logic              past_reg, past_next;
    logic              trunc_reg, trunc_next;
    logic              single_reg, single_next;
    logic [32:0]       ne_reg, ne_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [33:0]       acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    step_res_t         step;
    logic              can_push;
    logic              push;
    out_item_t         push_item;
    logic              long_pair;

    rmoe_step_unit #(
        .MAX_REPEATS(MAX_REPEATS)
    ) u_step (
        .acc   (acc_reg),
        .step  (item_reg.src_len),
        .limit (ne_reg),
        .cnt   (cnt_reg),
        .res   (step)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign can_push  = !out_valid_reg || out_ready;
    assign long_pair = item_reg.img_len > item_reg.src_len;

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        ra_next      = ra_reg;
        started_next = started_reg;
        past_next    = past_reg;
        trunc_next   = trunc_reg;
        single_next  = single_reg;
        ne_next      = ne_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        push         = 1'b0;
        push_item    = '{map_from: ra_reg[31:0], map_to: INVALID_TO,
                         last_of_run: 1'b0, truncated: trunc_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_item;
                    if (!started_reg)
                    begin
                        ra_next      = {2'b00, ws_reg};
                        started_next = 1'b1;
                        past_next    = 1'b0;
                    end
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                ne_next    = {2'b00, item_reg.img_base} + {1'b0, item_reg.img_len};
                prod_next  = PROD_W'(item_reg.src_len) * PROD_W'(MAX_REPEATS);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (item_reg.op == OP_FINISH)
                begin
                    trunc_next = 1'b0;
                    state_next = (ra_reg < {1'b0, we_reg}) ? S_GAP : S_CAP;
                end
                else if (past_reg || (ne_reg < {2'b00, ws_reg}))
                begin
                    state_next = S_IDLE;
                end
                else if (we_reg < {1'b0, item_reg.img_base})
                begin
                    past_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    trunc_next  = long_pair && ((item_reg.src_len == 32'd0) ||
                                  ({{CNT_W{1'b0}}, item_reg.img_len} > prod_reg));
                    single_next = !long_pair || (item_reg.src_len == 32'd0);
                    acc_next    = {3'b000, item_reg.img_base};
                    cnt_next    = '0;
                    state_next  = (ra_reg < {2'b00, item_reg.img_base}) ? S_GAP : S_BODY;
                end
            end
            S_GAP:
            begin
                if (can_push)
                begin
                    push       = 1'b1;
                    state_next = (item_reg.op == OP_FINISH) ? S_CAP : S_BODY;
                end
            end
            S_BODY:
            begin
                push_item = '{map_from: acc_reg[31:0],
                              map_to: {1'b0, item_reg.src_base},
                              last_of_run: single_reg || step.reached,
                              truncated: trunc_reg};
                if (can_push)
                begin
                    push     = 1'b1;
                    acc_next = step.next_addr;
                    cnt_next = cnt_reg + 1'b1;
                    if (single_reg || step.reached)
                    begin
                        if (single_reg || trunc_reg)
                        begin
                            ra_next = ne_reg;
                        end
                        else
                        begin
                            ra_next = step.next_addr[33] ? '1 : step.next_addr[32:0];
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            S_CAP:
            begin
                push_item = '{map_from: we_reg, map_to: INVALID_TO,
                              last_of_run: 1'b1, truncated: 1'b0};
                if (can_push)
                begin
                    push         = 1'b1;
                    started_next = 1'b0;
                    past_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_next       = push_item;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ra_reg        <= '0;
            started_reg   <= 1'b0;
            past_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            ws_reg        <= '0;
            we_reg        <= WINDOW_END_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            ra_reg        <= ra_next;
            started_reg   <= started_next;
            past_reg      <= past_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_WINDOW_START: ws_reg <= cfg_data[30:0];
                    CFG_WINDOW_END:   we_reg <= cfg_data;
                    default:          we_reg <= we_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        trunc_reg  <= trunc_next;
        single_reg <= single_next;
        ne_reg     <= ne_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
        out_reg    <= out_next;
    end

endmodule

`default_nettype wire

FILE: rtl/rmoe_checker.sv
// Port-level checker for range_map_to_omap_entries and the bind that attaches it.
// Depends on rmoe_pkg.
`default_nettype none

module rmoe_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire rmoe_pkg::in_item_t  in_item,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire rmoe_pkg::out_item_t out_item,
    input wire logic                cfg_valid,
    input wire logic                cfg_ready,
    input wire logic                cfg_index,
    input wire logic [31:0]         cfg_data
);
    import rmoe_pkg::*;

    logic unused_ok;
    assign unused_ok = ^{in_item, cfg_valid, cfg_ready, cfg_index, cfg_data};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("Output request changed while stalled.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Input ready right after a request was accepted.");

    a_busy_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.last_of_run |-> !in_ready)
        else $error("Input ready while an item still has entries pending.");

    a_cap_not_truncated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.last_of_run && (out_item.map_to == INVALID_TO)
        |-> !out_item.truncated)
        else $error("Cap entry carries the truncated flag.");

endmodule

bind range_map_to_omap_entries rmoe_checker u_rmoe_checker (.*);

`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for range_map_to_omap_entries: random and directed range pairs with random idling.
// Expected map entries come from an in-bench predictor kept in a small scoreboard class.
// Depends on rmoe_pkg and the range_map_to_omap_entries RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmoe_pkg::*;

    localparam int MAX_REPEATS = 32;
    localparam int IDLE_LIMIT = 2000;
    localparam int ITEM_COUNT = 100;
    localparam longint unsigned CURSOR_MAX = 64'h1_FFFF_FFFF;

    class omap_scoreboard;
        logic [30:0] win_start;
        logic [31:0] win_end;
        logic [32:0] cursor;
        bit in_run;
        bit beyond_window;
        out_item_t expected_entries[$];
        int errors;
        int requests;

        function new();
            win_start = '0;
            win_end = WINDOW_END_RESET;
            cursor = '0;
            in_run = 0;
            beyond_window = 0;
            errors = 0;
            requests = 0;
        endfunction

        function void write_reg(logic index, logic [31:0] data);
            if (index == CFG_WINDOW_START)
                win_start = data[30:0];
            else
                win_end = data;
        endfunction

        function out_item_t make_entry(longint unsigned addr_from, longint unsigned addr_to);
            out_item_t e;
            e.map_from = addr_from[31:0];
            e.map_to = addr_to[31:0];
            e.last_of_run = 1'b0;
            e.truncated = 1'b0;
            return e;
        endfunction

        function void note_request(in_item_t req);
            out_item_t batch[$];
            longint unsigned ns, nz, os, oz, ne, step_from, count;
            bit cut;
            requests++;
            ns = req.img_base;
            nz = req.img_len;
            os = req.src_base;
            oz = req.src_len;
            ne = ns + nz;
            cut = 0;
            if (!in_run)
            begin
                cursor = win_start;
                in_run = 1;
                beyond_window = 0;
            end
            if (req.op == OP_FINISH)
            begin
                if (cursor < win_end)
                    batch.insert(batch.size(), make_entry(cursor, INVALID_TO));
                batch.insert(batch.size(), make_entry(win_end, INVALID_TO));
                in_run = 0;
                beyond_window = 0;
            end
            else if (!beyond_window && ne >= win_start)
            begin
                if (win_end < ns)
                begin
                    beyond_window = 1;
                end
                else
                begin
                    if (cursor < ns)
                        batch.insert(batch.size(), make_entry(cursor, INVALID_TO));
                    if (nz > oz && oz == 0)
                    begin
                        batch.insert(batch.size(), make_entry(ns, os));
                        cut = 1;
                        cursor = ne;
                    end
                    else if (nz > oz)
                    begin
                        count = (nz + oz - 1) / oz;
                        if (count > MAX_REPEATS)
                        begin
                            count = MAX_REPEATS;
                            cut = 1;
                        end
                        step_from = ns;
                        for (longint unsigned i = 0; i < count; i++)
                        begin
                            batch.insert(batch.size(), make_entry(step_from, os));
                            step_from += oz;
                        end
                        if (cut)
                            cursor = ne;
                        else
                            cursor = (step_from > CURSOR_MAX) ? CURSOR_MAX : step_from;
                    end
                    else
                    begin
                        batch.insert(batch.size(), make_entry(ns, os));
                        cursor = ne;
                    end
                end
            end
            if (batch.size() != 0)
                batch[batch.size() - 1].last_of_run = 1'b1;
            foreach (batch[k])
            begin
                batch[k].truncated = cut;
                expected_entries.insert(expected_entries.size(), batch[k]);
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_entry(out_item_t got);
            out_item_t want;
            if (expected_entries.size() == 0)
            begin
                report_mismatch($sformatf("unexpected entry from=%h to=%h",
                                          got.map_from, got.map_to));
                return;
            end
            want = expected_entries.pop_front();
            if (got.map_from !== want.map_from)
                report_mismatch($sformatf("map_from %h, expected %h", got.map_from, want.map_from));
            if (got.map_to !== want.map_to)
                report_mismatch($sformatf("map_to %h, expected %h", got.map_to, want.map_to));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run %b, expected %b",
                                          got.last_of_run, want.last_of_run));
            if (got.truncated !== want.truncated)
                report_mismatch($sformatf("truncated %b, expected %b",
                                          got.truncated, want.truncated));
        endtask
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = CFG_WINDOW_START;
    logic [31:0] cfg_data = '0;

    omap_scoreboard sb = new();
    int hold_gap = 0;
    int send_quiet = 0;
    int take_quiet = 0;
    int idle_cycles = 0;

    range_map_to_omap_entries #(
        .MAX_REPEATS(MAX_REPEATS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int draw_wait(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            quiet = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h0;
            default: return {1'b0, 31'($urandom)};
        endcase
    endfunction

    function automatic in_item_t pair_item(longint unsigned ns, longint unsigned nz,
                                           longint unsigned os, longint unsigned oz);
        in_item_t req;
        req.op = OP_PAIR;
        req.img_base = ns[30:0];
        req.img_len = nz[31:0];
        req.src_base = os[30:0];
        req.src_len = oz[31:0];
        return req;
    endfunction

    function automatic in_item_t random_item();
        in_item_t req;
        req.op = $urandom_range(0, 1) ? OP_FINISH : OP_PAIR;
        req.img_base = 31'($urandom);
        req.img_len = pick_size();
        req.src_base = 31'($urandom);
        req.src_len = pick_size();
        return req;
    endfunction

    function automatic in_item_t finish_item();
        in_item_t req;
        req = random_item();
        req.op = OP_FINISH;
        return req;
    endfunction

    task send_request(in_item_t req);
        repeat (hold_gap) @(posedge clk);
        in_valid <= 1'b1;
        in_item <= req;
        do @(posedge clk); while (!in_ready);
        hold_gap = draw_wait(send_quiet);
        if (hold_gap != 0)
            in_valid <= 1'b0;
    endtask

    task stop_requests();
        if (hold_gap == 0)
        begin
            in_valid <= 1'b0;
            hold_gap = 1;
        end
    endtask

    task write_reg(logic index, logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task drain();
        stop_requests();
        @(posedge clk);
        while (sb.expected_entries.size() != 0 || !in_ready) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task set_window(logic [30:0] ws, logic [31:0] we);
        drain();
        write_reg(CFG_WINDOW_START, {1'b0, ws});
        write_reg(CFG_WINDOW_END, we);
    endtask

    task random_run();
        logic [30:0] ws;
        logic [31:0] we;
        longint unsigned addr, nz, oz;
        int pairs;
        case ($urandom_range(0, 9))
            0:
            begin
                ws = '0;
                we = WINDOW_END_RESET;
            end
            1:
            begin
                ws = 31'($urandom);
                we = pick_size();
            end
            2:
            begin
                ws = 31'h7FFF_FFFF;
                we = 32'h8000_0000;
            end
            3:
            begin
                ws = 31'($urandom_range(0, 'h100));
                we = '0;
            end
            default:
            begin
                ws = 31'($urandom_range(0, 'h4000));
                we = {1'b0, ws} + $urandom_range(0, 'h8000);
            end
        endcase
        if ($urandom_range(0, 5) != 0)
            set_window(ws, we);
        else
            ws = sb.win_start;
        pairs = $urandom_range(0, 8);
        addr = (ws > 'h80) ? ws - $urandom_range(0, 'h80) : 0;
        for (int k = 0; k < pairs; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_request(random_item());
                continue;
            end
            if ($urandom_range(0, 2) == 0)
                addr += $urandom_range(1, 'h200);
            if (addr > 'h7FFF_FFFF)
                addr = ws;
            case ($urandom_range(0, 9))
                0: nz = 0;
                1: nz = 'h8000_0000;
                default: nz = $urandom_range(1, 'h400);
            endcase
            case ($urandom_range(0, 5))
                0: oz = nz;
                1: oz = 0;
                2: oz = $urandom_range(1, 'h20);
                3: oz = nz + $urandom_range(0, 'h100);
                default: oz = $urandom_range(1, (nz > 0) ? nz : 1);
            endcase
            if (oz > 'h8000_0000)
                oz = 'h8000_0000;
            send_request(pair_item(addr, nz, $urandom, oz));
            addr += nz;
        end
        if ($urandom_range(0, 7) != 0)
            send_request(finish_item());
    endtask

    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait(take_quiet);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_request(in_item);
            if (out_valid && out_ready)
                sb.check_entry(out_item);
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_window(31'h100, 32'h1_0000);
        send_request(pair_item('h0, 'h10, 'h1000, 'h10));
        send_request(pair_item('h200, 'h100, 'h5000, 'h100));
        send_request(pair_item('h300, 'h450, 'h6000, 'h100));
        send_request(pair_item('h800, 'h100, 'h7000, 'h0));
        send_request(pair_item('h900, 'h1000, 'h7100, 'h10));
        send_request(pair_item('h1900, 'h20, 'h7FFF_FFFF, 'h40));
        send_request(pair_item('h2_0000, 'h10, 'h0, 'h10));
        send_request(pair_item('h2_0100, 'h10, 'h0, 'h10));
        send_request(finish_item());
        send_request(finish_item());

        set_window(31'h7FFF_FFFF, 32'h8000_0000);
        send_request(pair_item('h7FFF_FFFF, 'h8000_0000, 'h7FFF_FFFF, 'h8000_0000));
        send_request(pair_item('h7FFF_FFFF, 'h8000_0000, 'h0, 'h1));
        send_request(pair_item('h7FFF_FFFF, 'h8000_0000, 'h1234, 'h7FFF_FFFF));
        send_request(finish_item());

        set_window(31'h0, 32'h0);
        send_request(pair_item('h0, 'h0, 'h55, 'h0));
        send_request(pair_item('h1, 'h10, 'h0, 'h10));
        send_request(finish_item());

        set_window(31'h40, 32'h1000);
        send_request(pair_item('h50, 'h10, 'h10, 'h10));
        set_window(31'h2000, 32'h60);
        send_request(pair_item('h70, 'h10, 'h20, 'h10));
        send_request(finish_item());

        while (sb.requests < ITEM_COUNT)
            random_run();

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_entries.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
